// File: rtl/wft_pkg.sv
// Package for the word frequency table: sizes, codes and word types.
`timescale 1ns / 1ps
`default_nettype none

package wft_pkg;

    // Table geometry
    localparam int MAX_ENTRIES    = 256;
    localparam int MAX_WORD_CHARS = 40;
    localparam int ENT_W          = $clog2(MAX_ENTRIES);
    localparam int LEN_W          = 6;
    localparam int CHARS_DEPTH    = MAX_ENTRIES * MAX_WORD_CHARS;
    localparam int CA_W           = $clog2(CHARS_DEPTH);
    localparam int PEND_AW        = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
    localparam int CNT_W          = 32;

    // Command queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    // Input opcodes
    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_INC  = 3'd0,
        ST_ADD  = 3'd1,
        ST_FULL = 3'd2,
        ST_DATA = 3'd3,
        ST_BAD  = 3'd4,
        ST_CLR  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_READ,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_in;
        logic       word_end;
        logic [7:0] entry_select;
    } t_word_in;

    typedef struct packed {
        t_status    status;
        logic [7:0] entry_index;
        logic [31:0] occurrences;
        logic [7:0] char_out;
        logic       last_out;
        logic [8:0] entries_used;
    } t_result;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ch;
        logic       word_end;
        logic [7:0] sel;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LEN_RD,
        BK_LEN_CHK,
        BK_CHR_RD,
        BK_CHR_CHK,
        BK_CNT_RD,
        BK_CNT_UPD,
        BK_CPY_RD,
        BK_CPY_WR,
        BK_APPEND,
        BK_RD_HDR,
        BK_RD_CNT,
        BK_RD_CHR,
        BK_RD_OUT,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/wft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/wft_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module wft_front import wft_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  t_word_in      i_word,
    output logic          full,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_take
);

    t_cmd             r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wr, n_wr;
    logic [FQ_AW-1:0] r_rd, n_rd;
    logic [FQ_AW:0]   r_cnt, n_cnt;
    logic             wr_en;
    t_cmd             cmd_in;

    // Classify the incoming word; unused opcode is dropped
    always_comb begin
        cmd_in.ch       = i_word.char_in;
        cmd_in.word_end = i_word.word_end;
        cmd_in.sel      = i_word.entry_select;
        cmd_in.kind     = CMD_CHAR;
        wr_en           = 1'b0;
        unique case (i_word.opcode)
            OP_CHAR: begin
                cmd_in.kind = CMD_CHAR;
                wr_en       = push && !full;
            end
            OP_READ: begin
                cmd_in.kind = CMD_READ;
                wr_en       = push && !full;
            end
            OP_CLEAR: begin
                cmd_in.kind = CMD_CLEAR;
                wr_en       = push && !full;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Advance queue pointers
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_cmd_take) begin
            n_rd = r_rd + 1'b1;
        end
        if (wr_en && !i_cmd_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!wr_en && i_cmd_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    assign full        = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

endmodule

`default_nettype wire

// File: rtl/wft_back.sv
// Back end: buffers words, searches and updates the table, emits results.
`timescale 1ns / 1ps
`default_nettype none

module wft_back import wft_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    input  wire logic pop,
    output t_result   o_result
);

    t_back_state      r_state, n_state;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [LEN_W-1:0] r_wlen, n_wlen;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [ENT_W:0]   r_used, n_used;
    logic [ENT_W:0]   r_ent, n_ent;
    logic [CA_W:0]    r_base, n_base;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_result          r_res, n_res;
    logic             r_out_v;
    t_result          r_out;

    logic             out_free;
    logic             out_load;
    t_result          out_data;

    // RAM ports
    logic               pend_we;
    logic [PEND_AW-1:0] pend_waddr;
    logic [7:0]         pend_rdata;
    logic               chr_we;
    logic [CA_W-1:0]    chr_addr;
    logic [7:0]         chr_rdata;
    logic               len_we;
    logic [LEN_W-1:0]   len_rdata;
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [ENT_W-1:0]   ent_addr;
    logic [LEN_W-1:0]   plen_next;

    assign out_free = !r_out_v || pop;
    assign chr_addr = CA_W'(r_base + (CA_W+1)'(r_idx));
    assign ent_addr = ENT_W'(r_ent);
    assign plen_next = (int'(r_plen) < MAX_WORD_CHARS) ? r_plen + 1'b1 : r_plen;

    wft_ram #(.WIDTH(8), .DEPTH(MAX_WORD_CHARS)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (i_cmd.ch),
        .i_raddr (PEND_AW'(r_idx)),
        .o_rdata (pend_rdata)
    );

    wft_ram #(.WIDTH(8), .DEPTH(CHARS_DEPTH)) u_chars (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (chr_addr),
        .i_wdata (pend_rdata),
        .i_raddr (chr_addr),
        .o_rdata (chr_rdata)
    );

    wft_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_lens (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (ent_addr),
        .i_wdata (r_wlen),
        .i_raddr (ent_addr),
        .o_rdata (len_rdata)
    );

    wft_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTRIES)) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (ent_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (ent_addr),
        .o_rdata (cnt_rdata)
    );

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_plen     = r_plen;
        n_wlen     = r_wlen;
        n_idx      = r_idx;
        n_used     = r_used;
        n_ent      = r_ent;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_res      = r_res;
        o_cmd_take = 1'b0;
        pend_we    = 1'b0;
        pend_waddr = PEND_AW'(r_plen);
        chr_we     = 1'b0;
        len_we     = 1'b0;
        cnt_we     = 1'b0;
        cnt_wdata  = r_cnt;
        out_load   = 1'b0;
        out_data   = r_res;

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_CHAR: begin
                            pend_we = (int'(r_plen) < MAX_WORD_CHARS);
                            n_plen  = plen_next;
                            if (i_cmd.word_end) begin
                                n_wlen  = plen_next;
                                n_plen  = '0;
                                n_ent   = '0;
                                n_base  = '0;
                                n_state = BK_LEN_RD;
                            end
                        end
                        CMD_READ: begin
                            n_res.status       = ST_DATA;
                            n_res.entry_index  = i_cmd.sel;
                            n_res.char_out     = '0;
                            n_res.last_out     = 1'b1;
                            n_res.entries_used = 9'(r_used);
                            if (int'(i_cmd.sel) >= int'(r_used)
                                || int'(i_cmd.sel) >= MAX_ENTRIES) begin
                                n_res.status      = ST_BAD;
                                n_res.occurrences = '0;
                                n_state           = BK_EMIT;
                            end else begin
                                n_ent   = (ENT_W+1)'(i_cmd.sel);
                                n_base  = (CA_W+1)'(int'(i_cmd.sel) * MAX_WORD_CHARS);
                                n_state = BK_RD_HDR;
                            end
                        end
                        CMD_CLEAR: begin
                            n_used             = '0;
                            n_plen             = '0;
                            n_res.status       = ST_CLR;
                            n_res.entry_index  = '0;
                            n_res.occurrences  = '0;
                            n_res.char_out     = '0;
                            n_res.last_out     = 1'b1;
                            n_res.entries_used = '0;
                            n_state            = BK_EMIT;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end

            // Walk the stored entries
            BK_LEN_RD: begin
                n_idx = '0;
                if (r_ent == r_used) begin
                    if (int'(r_used) >= MAX_ENTRIES) begin
                        n_res.status       = ST_FULL;
                        n_res.entry_index  = '0;
                        n_res.occurrences  = '0;
                        n_res.char_out     = '0;
                        n_res.last_out     = 1'b1;
                        n_res.entries_used = 9'(r_used);
                        n_state            = BK_EMIT;
                    end else if (r_wlen == '0) begin
                        n_state = BK_APPEND;
                    end else begin
                        n_state = BK_CPY_RD;
                    end
                end else begin
                    n_state = BK_LEN_CHK;
                end
            end

            BK_LEN_CHK: begin
                if (len_rdata == r_wlen) begin
                    n_state = (r_wlen == '0) ? BK_CNT_RD : BK_CHR_RD;
                end else begin
                    n_ent   = r_ent + 1'b1;
                    n_base  = r_base + (CA_W+1)'(MAX_WORD_CHARS);
                    n_state = BK_LEN_RD;
                end
            end

            BK_CHR_RD: begin
                n_state = BK_CHR_CHK;
            end

            // Compare one character; drop to the next entry on mismatch
            BK_CHR_CHK: begin
                if (chr_rdata != pend_rdata) begin
                    n_ent   = r_ent + 1'b1;
                    n_base  = r_base + (CA_W+1)'(MAX_WORD_CHARS);
                    n_state = BK_LEN_RD;
                end else if (r_idx + 1'b1 == r_wlen) begin
                    n_state = BK_CNT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = BK_CHR_RD;
                end
            end

            BK_CNT_RD: begin
                n_state = BK_CNT_UPD;
            end

            // Saturating increment of the matched count
            BK_CNT_UPD: begin
                cnt_wdata          = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
                cnt_we             = 1'b1;
                n_res.status       = ST_INC;
                n_res.entry_index  = 8'(r_ent);
                n_res.occurrences  = cnt_wdata;
                n_res.char_out     = '0;
                n_res.last_out     = 1'b1;
                n_res.entries_used = 9'(r_used);
                n_state            = BK_EMIT;
            end

            // Copy the pending word into the new entry
            BK_CPY_RD: begin
                n_state = BK_CPY_WR;
            end

            BK_CPY_WR: begin
                chr_we = 1'b1;
                if (r_idx + 1'b1 == r_wlen) begin
                    n_state = BK_APPEND;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = BK_CPY_RD;
                end
            end

            BK_APPEND: begin
                len_we             = 1'b1;
                cnt_we             = 1'b1;
                cnt_wdata          = CNT_W'(1);
                n_used             = r_used + 1'b1;
                n_res.status       = ST_ADD;
                n_res.entry_index  = 8'(r_ent);
                n_res.occurrences  = CNT_W'(1);
                n_res.char_out     = '0;
                n_res.last_out     = 1'b1;
                n_res.entries_used = 9'(r_used + 1'b1);
                n_state            = BK_EMIT;
            end

            // Read out one entry
            BK_RD_HDR: begin
                n_state = BK_RD_CNT;
            end

            BK_RD_CNT: begin
                n_wlen            = len_rdata;
                n_cnt             = cnt_rdata;
                n_idx             = '0;
                n_res.occurrences = cnt_rdata;
                n_state           = (len_rdata == '0) ? BK_EMIT : BK_RD_CHR;
            end

            BK_RD_CHR: begin
                n_state = BK_RD_OUT;
            end

            BK_RD_OUT: begin
                out_data.status       = ST_DATA;
                out_data.entry_index  = r_res.entry_index;
                out_data.occurrences  = r_cnt;
                out_data.char_out     = chr_rdata;
                out_data.last_out     = (r_idx + 1'b1 == r_wlen);
                out_data.entries_used = 9'(r_used);
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_idx + 1'b1 == r_wlen) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_RD_CHR;
                    end
                end
            end

            BK_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end

            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= '0;
            r_used  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_plen <= n_plen;
            r_used <= n_used;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (pop) begin
                r_out_v <= 1'b0;
            end
        end
        r_wlen <= n_wlen;
        r_idx  <= n_idx;
        r_ent  <= n_ent;
        r_base <= n_base;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign empty    = !r_out_v;
    assign o_result = r_out;

    // Checks
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= MAX_ENTRIES)
        else $error("entry count beyond table size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_v || pop))
        else $error("result overwritten before pop");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_plen) <= MAX_WORD_CHARS)
        else $error("pending word longer than limit");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == BK_IDLE && i_cmd_valid))
        else $error("command taken while busy");

endmodule

`default_nettype wire

// File: rtl/word_frequency_table.sv
// Top level of the word frequency table: front queue and table engine.
// A character word is taken by the back end when idle. A word end walks the stored
// entries, reading and checking each length and comparing character by character, then
// reads and bumps the count, or copies the word character by character and appends it.
// A read fetches the header and count, then reads out each character; bad index and clear
// go straight to the result. The back end takes no new command until it is idle again.
// Reset (synchronous, active low) empties the table, the pending word and both queues.
`timescale 1ns / 1ps
`default_nettype none

module word_frequency_table import wft_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    input  t_word_in  i_word,
    output logic      full,
    output logic      empty,
    input  wire logic pop,
    output t_result   o_result
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    wft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_word      (i_word),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    wft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// File: bench/word_frequency_table_tb.sv
// Self-checking testbench for the word frequency table with its own table predictor.
`timescale 1ns / 1ps
`default_nettype none

module word_frequency_table_tb;
    import wft_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 300000;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    t_word_in i_word;
    logic     full;
    logic     empty;
    logic     pop;
    t_result  o_result;

    word_frequency_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_word  (i_word),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // Predictor state: open word, table of distinct words
    logic [7:0]  open_chars [MAX_WORD_CHARS];
    int          open_len;
    logic [7:0]  tbl_chars [MAX_ENTRIES][MAX_WORD_CHARS];
    int          tbl_len [MAX_ENTRIES];
    logic [31:0] tbl_cnt [MAX_ENTRIES];
    int          tbl_used;

    t_result pending_results[$];
    int      error_count;
    int      results_seen;
    int      words_closed;
    int      reads_done;
    int      idle_pct;
    int      stall_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result make_result(t_status st, logic [7:0] idx, logic [31:0] occ,
                                            logic [7:0] ch, logic last);
        t_result r;
        r.status       = st;
        r.entry_index  = idx;
        r.occurrences  = occ;
        r.char_out     = ch;
        r.last_out     = last;
        r.entries_used = tbl_used[8:0];
        return r;
    endfunction

    // Close the open word: look it up, bump it or append it, or report a full table
    task automatic close_open_word();
        bit hit;
        for (int e = 0; e < tbl_used; e++) begin
            hit = (tbl_len[e] == open_len);
            for (int i = 0; hit && i < open_len; i++)
                if (tbl_chars[e][i] != open_chars[i]) hit = 0;
            if (hit) begin
                if (tbl_cnt[e] != 32'hFFFF_FFFF) tbl_cnt[e]++;
                open_len = 0;
                pending_results.push_back(make_result(ST_INC, e[7:0], tbl_cnt[e], 8'd0, 1'b1));
                return;
            end
        end
        open_len = 0;
        if (tbl_used >= MAX_ENTRIES) begin
            pending_results.push_back(make_result(ST_FULL, 8'd0, 32'd0, 8'd0, 1'b1));
            return;
        end
        for (int i = 0; i < MAX_WORD_CHARS; i++) tbl_chars[tbl_used][i] = open_chars[i];
        tbl_len[tbl_used] = 0;
        tbl_cnt[tbl_used] = 32'd1;
        tbl_used++;
        pending_results.push_back(make_result(ST_ADD, 8'(tbl_used - 1), 32'd1, 8'd0, 1'b1));
    endtask

    // Work out the results one accepted word causes
    task automatic predict_table(t_word_in w);
        int sel;
        sel = w.entry_select;
        case (w.opcode)
            OP_CHAR: begin
                if (open_len < MAX_WORD_CHARS) begin
                    open_chars[open_len] = w.char_in;
                    open_len++;
                end
                if (w.word_end) begin
                    // the stored length is the truncated open length
                    int keep_len;
                    keep_len = open_len;
                    close_open_word();
                    if (pending_results[$].status == ST_ADD)
                        tbl_len[tbl_used - 1] = keep_len;
                    words_closed++;
                end
            end
            OP_READ: begin
                reads_done++;
                if (sel >= tbl_used) begin
                    pending_results.push_back(make_result(ST_BAD, 8'(sel), 32'd0, 8'd0, 1'b1));
                end else begin
                    for (int i = 0; i < tbl_len[sel]; i++)
                        pending_results.push_back(make_result(ST_DATA, 8'(sel), tbl_cnt[sel],
                            tbl_chars[sel][i], i + 1 == tbl_len[sel]));
                end
            end
            OP_CLEAR: begin
                tbl_used = 0;
                open_len = 0;
                pending_results.push_back(make_result(ST_CLR, 8'd0, 32'd0, 8'd0, 1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, t_result got, t_result want);
        error_count++;
        $display({"%0t MISMATCH %s: got st=%0d idx=%0d occ=%0d ch=%0d last=%0d used=%0d, ",
                  "want st=%0d idx=%0d occ=%0d ch=%0d last=%0d used=%0d"},
                 $realtime, what, got.status, got.entry_index, got.occurrences, got.char_out,
                 got.last_out, got.entries_used, want.status, want.entry_index,
                 want.occurrences, want.char_out, want.last_out, want.entries_used);
    endtask

    // Pop side: random stalls, compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_result, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.status != want.status)
                        report_mismatch("status", o_result, want);
                    else if (o_result.entry_index != want.entry_index)
                        report_mismatch("entry_index", o_result, want);
                    else if (o_result.occurrences != want.occurrences)
                        report_mismatch("occurrences", o_result, want);
                    else if (o_result.char_out != want.char_out)
                        report_mismatch("char_out", o_result, want);
                    else if (o_result.last_out != want.last_out)
                        report_mismatch("last_out", o_result, want);
                    else if (o_result.entries_used != want.entries_used)
                        report_mismatch("entries_used", o_result, want);
                end
            end
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no progress, %0d results outstanding",
                         $realtime, pending_results.size());
                $display("word_frequency_table_tb: FAIL");
                $finish;
            end
        end
    end

    // Send one word; hold push until accepted, then maybe idle
    task automatic send_word(logic [1:0] op, logic [7:0] ch, logic fin, logic [7:0] sel);
        t_word_in w;
        w.opcode       = op;
        w.char_in      = ch;
        w.word_end     = fin;
        w.entry_select = sel;
        push   <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (full);
        predict_table(w);
        if ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(logic [7:0] txt[$]);
        for (int i = 0; i < txt.size(); i++)
            send_word(OP_CHAR, txt[i], i == txt.size() - 1, $urandom_range(255));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Directed: add, bump, prefix, long words, reads, bad index, ignored opcode, clear
    task automatic test_directed();
        logic [7:0] txt[$];
        send_text('{8'h61});
        send_text('{8'h61});
        send_text('{8'h61, 8'h62});
        send_text('{8'h00, 8'hFF});
        txt = {};
        for (int i = 0; i < MAX_WORD_CHARS + 5; i++) txt.push_back(8'(8'h30 + i));
        send_text(txt);
        txt = txt[0:MAX_WORD_CHARS - 1];
        send_text(txt);
        send_word(OP_NONE, 8'hFF, 1'b1, 8'hFF);
        send_word(OP_READ, 8'h00, 1'b0, 8'd0);
        send_word(OP_READ, 8'h00, 1'b0, 8'd3);
        send_word(OP_READ, 8'h00, 1'b0, 8'd4);
        send_word(OP_READ, 8'h00, 1'b0, 8'd255);
        send_word(OP_CHAR, 8'h61, 1'b0, 8'd0);
        send_word(OP_CLEAR, 8'h00, 1'b0, 8'd0);
        send_word(OP_READ, 8'h00, 1'b0, 8'd0);
        drain_results();
    endtask

    // Fill every entry with one-character words, overflow it, bump a stored word,
    // read the top entry, then clear
    task automatic test_table_full();
        idle_pct = 0;
        for (int e = 0; e < MAX_ENTRIES; e++) send_text('{8'(e)});
        send_text('{8'h21, 8'h22, 8'h23});
        send_text('{8'hFF});
        send_word(OP_READ, 8'h00, 1'b0, 8'd255);
        send_word(OP_CLEAR, 8'h00, 1'b0, 8'd0);
        drain_results();
        idle_pct = 32;
    endtask

    // Random words from a small vocabulary so that repeats occur, plus noise
    task automatic test_random(int n_items);
        logic [7:0] vocab[8][$];
        logic [7:0] txt[$];
        int sent;
        int pick;
        int wlen;
        sent = 0;
        for (int v = 0; v < 8; v++) begin
            vocab[v] = {};
            wlen = $urandom_range(1, (v == 7) ? 44 : 5);
            for (int i = 0; i < wlen; i++)
                vocab[v].push_back(8'($urandom_range(255)));
        end
        while (sent < n_items) begin
            idle_pct = (sent > n_items / 3 && sent < n_items / 2) ? 0 : 32;
            pick = $urandom_range(99);
            if (pick < 60) begin
                txt = vocab[$urandom_range(7)];
                if ($urandom_range(3) == 0) txt[$urandom_range(txt.size() - 1)] ^= 8'h01;
                send_text(txt);
                sent += txt.size();
            end else if (pick < 80) begin
                send_word(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          8'($urandom_range(0, 10)));
                sent++;
            end else if (pick < 85) begin
                send_word(OP_READ, 8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
                sent++;
            end else if (pick < 88) begin
                send_word(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                sent++;
            end else if (pick < 92) begin
                send_word(OP_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end else begin
                send_word(OP_CHAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                sent++;
            end
        end
        drain_results();
    endtask

    // Sequence
    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_word       = '0;
        open_len     = 0;
        tbl_used     = 0;
        error_count  = 0;
        results_seen = 0;
        words_closed = 0;
        reads_done   = 0;
        idle_pct     = 32;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(20);
        repeat (200) @(posedge i_clk);
        $display("covered %0d closed words, %0d reads, %0d results checked",
                 words_closed, reads_done, results_seen);
        $display("including a full table, truncated words, bad indexes and clears");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("word_frequency_table_tb: PASS");
        end else begin
            $display("word_frequency_table_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/wft_pkg.sv
rtl/wft_ram.sv
rtl/wft_front.sv
rtl/wft_back.sv
rtl/word_frequency_table.sv
bench/word_frequency_table_tb.sv
